@@ rtl/core/irpwfe_pkg.sv @@
// Shared types, constants and the check-bit function for the IR pulse-width frame encoder.
`timescale 1ns / 1ps
package irpwfe_pkg;

   localparam int DATA_BITS   = 7;
   localparam int CHECK_BITS  = 5;
   localparam int WORD_BITS   = CHECK_BITS + DATA_BITS;
   localparam int LEN_BITS    = 16;
   localparam int PULSES      = 2 + 2 * WORD_BITS;
   localparam int IDX_BITS    = $clog2(PULSES);
   localparam int CSR_IDX_BITS = 3;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [LEN_BITS-1:0] START_MARK_RST  = 16'd2400;
   localparam logic [LEN_BITS-1:0] START_SPACE_RST = 16'd600;
   localparam logic [LEN_BITS-1:0] ONE_MARK_RST    = 16'd1200;
   localparam logic [LEN_BITS-1:0] ZERO_MARK_RST   = 16'd600;
   localparam logic [LEN_BITS-1:0] BIT_SPACE_RST   = 16'd600;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_MARK  = 3'd0,
      CSR_START_SPACE = 3'd1,
      CSR_ONE_MARK    = 3'd2,
      CSR_ZERO_MARK   = 3'd3,
      CSR_BIT_SPACE   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] start_mark_len;
      logic [LEN_BITS-1:0] start_space_len;
      logic [LEN_BITS-1:0] one_mark_len;
      logic [LEN_BITS-1:0] zero_mark_len;
      logic [LEN_BITS-1:0] bit_space_len;
   } timing_type;

   typedef logic [WORD_BITS-1:0] word_type;

   // check bits in the upper part, payload below; bit WORD_BITS-1 goes out first
   function automatic word_type make_word(input logic [DATA_BITS-1:0] data);
      logic [15:0] crc;
      crc = CRC_SEED ^ {{(16-DATA_BITS){1'b0}}, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
         else        crc = crc >> 1;
      end
      return {crc[CHECK_BITS-1:0], data};
   endfunction

endpackage

@@ rtl/core/ir_pulse_width_frame_encoder_top.sv @@
// Top level of the IR pulse-width frame encoder: timing registers and the front/back pipeline.
//
// Requests: req_data_value is taken at a clock edge with req_push high and req_full low.
// Each request yields one frame of 26 responses (start mark, start space, then
// 12 mark/space pairs for 5 check bits and 7 data bits, most significant first).
// Responses: while rsp_empty is low the oldest pulse sits on rsp_carrier_on,
// rsp_pulse_len and rsp_frame_end; it is taken at an edge with rsp_pop high.
// rsp_frame_end marks the last space of a frame.
// A request passes the front-end register and the queue before its first pulse is registered.
// Throughput: one pulse per cycle while the receiver keeps popping; the back end emits the
// next frame straight after the last pulse of the previous one.
// The front end holds one request and the queue two frame words, one of them the
// frame in flight, so up to two requests are taken ahead of it before req_full rises.
// When the receiver stalls, the response register holds its pulse and the
// back end, queue and front end fill in turn, then req_full is raised.
// Timing registers are written through csr_wen/csr_index/csr_wdata; the user must write them
// only while idle, as the block does not enforce it. Unknown indexes are ignored. Synchronous
// reset empties every stage and restores the default timings (2400/600/1200/600/600 us).
`timescale 1ns / 1ps
module ir_pulse_width_frame_encoder_top
   import irpwfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [DATA_BITS-1:0]    req_data_value,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic                    rsp_carrier_on,
   output logic [LEN_BITS-1:0]     rsp_pulse_len,
   output logic                    rsp_frame_end,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [LEN_BITS-1:0]     csr_wdata
);

   timing_type timing_ff, timing_in;
   logic       q_push, q_full, q_pop, q_nonempty;
   word_type   q_word, head_word;

   always_comb begin
      timing_in = timing_ff;
      if (csr_wen) begin
         unique case (csr_idx_type'(csr_index))
            CSR_START_MARK:  timing_in.start_mark_len  = csr_wdata;
            CSR_START_SPACE: timing_in.start_space_len = csr_wdata;
            CSR_ONE_MARK:    timing_in.one_mark_len    = csr_wdata;
            CSR_ZERO_MARK:   timing_in.zero_mark_len   = csr_wdata;
            CSR_BIT_SPACE:   timing_in.bit_space_len   = csr_wdata;
            default:         timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.start_mark_len  <= START_MARK_RST;
         timing_ff.start_space_len <= START_SPACE_RST;
         timing_ff.one_mark_len    <= ONE_MARK_RST;
         timing_ff.zero_mark_len   <= ZERO_MARK_RST;
         timing_ff.bit_space_len   <= BIT_SPACE_RST;
      end else begin
         timing_ff <= timing_in;
      end
   end

   irpwfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_value (req_data_value),
      .q_push         (q_push),
      .q_word         (q_word),
      .q_full         (q_full)
   );

   irpwfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_word),
      .full      (q_full),
      .pop       (q_pop),
      .head_word (head_word),
      .nonempty  (q_nonempty)
   );

   irpwfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .timing         (timing_ff),
      .head_word      (head_word),
      .head_valid     (q_nonempty),
      .head_pop       (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_carrier_on (rsp_carrier_on),
      .rsp_pulse_len  (rsp_pulse_len),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

@@ rtl/core/irpwfe_front.sv @@
// Front end: takes a request, works out its check bits and queues the frame word.
`timescale 1ns / 1ps
module irpwfe_front
   import irpwfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [DATA_BITS-1:0] req_data_value,
   output logic                 q_push,
   output word_type             q_word,
   input  logic                 q_full
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     load;

   assign q_push   = valid_ff && !q_full;
   assign q_word   = word_ff;
   assign req_full = valid_ff && q_full;
   assign load     = req_push && !req_full;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (q_push) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         word_in  = make_word(req_data_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      word_ff <= word_in;
   end

endmodule

@@ rtl/core/irpwfe_queue.sv @@
// Short queue of frame words between front and back end.
`timescale 1ns / 1ps
module irpwfe_queue
   import irpwfe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   output logic     full,
   input  logic     pop,
   output word_type head_word,
   output logic     nonempty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   word_type mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign nonempty  = (count_ff != '0);
   assign head_word = mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_word;
   end

endmodule

@@ rtl/core/irpwfe_back.sv @@
// Back end: steps through the 26 pulses of the head frame into the response register.
`timescale 1ns / 1ps
module irpwfe_back
   import irpwfe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  timing_type          timing,
   input  word_type            head_word,
   input  logic                head_valid,
   output logic                head_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_carrier_on,
   output logic [LEN_BITS-1:0] rsp_pulse_len,
   output logic                rsp_frame_end
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PULSES - 1);
   localparam logic [IDX_BITS-1:0] TWO      = IDX_BITS'(2);
   localparam logic [3:0]          TOP_BIT  = 4'(WORD_BITS - 1);

   logic                valid_ff, valid_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in, rel;
   logic                carrier_ff, carrier_in, end_ff, end_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic                advance, bit_val;
   logic [3:0]          bit_pos;

   assign advance  = head_valid && (!valid_ff || rsp_pop);
   assign head_pop = advance && (idx_ff == LAST_IDX);
   assign rel      = idx_ff - TWO;
   assign bit_pos  = TOP_BIT - 4'(rel[IDX_BITS-1:1]);
   assign bit_val  = head_word[bit_pos];

   assign rsp_empty      = !valid_ff;
   assign rsp_carrier_on = carrier_ff;
   assign rsp_pulse_len  = len_ff;
   assign rsp_frame_end  = end_ff;

   always_comb begin
      valid_in   = valid_ff;
      idx_in     = idx_ff;
      carrier_in = carrier_ff;
      len_in     = len_ff;
      end_in     = end_ff;
      if (rsp_pop) valid_in = 1'b0;
      if (advance) begin
         valid_in   = 1'b1;
         idx_in     = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         carrier_in = !idx_ff[0];
         end_in     = (idx_ff == LAST_IDX);
         if (idx_ff == '0)         len_in = timing.start_mark_len;
         else if (idx_ff == 5'(1)) len_in = timing.start_space_len;
         else if (!idx_ff[0])      len_in = bit_val ? timing.one_mark_len
                                                    : timing.zero_mark_len;
         else                      len_in = timing.bit_space_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      carrier_ff <= carrier_in;
      len_ff     <= len_in;
      end_ff     <= end_in;
   end

endmodule
